// ===== rtl/ledser_pkg.sv =====
// Shared types and constants for the two-wire LED driver byte serializer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ledser_pkg;

    // Top two bits of a command both set: no stop condition follows
    localparam logic [1:0] NO_STOP_BITS = 2'b11;

    // Segment codes of the back-end sequencer
    localparam logic [1:0] SEG_START = 2'd0;
    localparam logic [1:0] SEG_BITS  = 2'd1;
    localparam logic [1:0] SEG_ACK   = 2'd2;
    localparam logic [1:0] SEG_STOP  = 2'd3;

    localparam logic [1:0] SUB_LAST_START = 2'd3;
    localparam logic [1:0] SUB_LAST_BIT   = 2'd2;
    localparam logic [1:0] SUB_LAST_ACK   = 2'd2;
    localparam logic [1:0] SUB_LAST_STOP  = 2'd3;
    localparam logic [2:0] IDX_LAST_BIT   = 3'd7;

    // One classified byte, as queued between front and back
    typedef struct packed {
        logic       has_start;
        logic       has_stop;
        logic [7:0] value;
    } ledser_desc_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } ledser_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/ledser_front.sv =====
// Front end: accepts a byte request and classifies it (start, stop).
// Depends on ledser_pkg.
`default_nettype none

module ledser_front
    import ledser_pkg::*;
(
    input  wire logic          start,
    input  wire logic          req_type,
    input  wire logic [7:0]    byte_value,
    input  wire logic          last_data,
    input  wire ledser_qstat_t qstat,
    output logic               busy,
    output logic               push,
    output ledser_desc_t       push_desc
);

    always_comb
    begin
        busy                = qstat.full;
        push                = start && !qstat.full;
        push_desc.has_start = !req_type;
        push_desc.value     = byte_value;
        // Commands stop unless both top bits are set; data stops on the last byte
        if (req_type)
        begin
            push_desc.has_stop = last_data;
        end
        else
        begin
            push_desc.has_stop = (byte_value[7:6] != NO_STOP_BITS);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ledser_queue.sv =====
// Short FIFO of classified bytes between front and back ends.
// Depends on ledser_pkg.
`default_nettype none

module ledser_queue
    import ledser_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ledser_desc_t  push_desc,
    input  wire logic          pop,
    output ledser_desc_t       head_desc,
    output ledser_qstat_t      qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ledser_desc_t     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        qstat.empty = (count_reg == '0);
        qstat.full  = (count_reg == CNT_FULL);
        do_push     = push && !qstat.full;
        do_pop      = pop && !qstat.empty;
        head_desc   = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ledser_back.sv =====
// Back end: sequencer that walks an optional start, eight bits, ack slot and
// optional stop, emitting one pin phase per cycle while active. Depends on ledser_pkg.
`default_nettype none

module ledser_back
    import ledser_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ledser_desc_t  head_desc,
    input  wire ledser_qstat_t qstat,
    output logic               pop,
    output logic               strobe,
    output logic               clock_level,
    output logic               data_level,
    output logic               data_released,
    output logic               last_phase
);

    logic         active_reg;
    logic         active_next;
    logic [1:0]   seg_reg;
    logic [1:0]   seg_next;
    logic [2:0]   idx_reg;
    logic [2:0]   idx_next;
    logic [1:0]   sub_reg;
    logic [1:0]   sub_next;
    ledser_desc_t desc_reg;
    logic         done;
    logic [2:0]   prev_idx;

    assign prev_idx = 3'(idx_reg - 3'd1);

    // Final phase of the current byte
    always_comb
    begin
        case (seg_reg)
            SEG_ACK:  done = (sub_reg == SUB_LAST_ACK) && !desc_reg.has_stop;
            SEG_STOP: done = (sub_reg == SUB_LAST_STOP);
            default:  done = 1'b0;
        endcase
    end

    always_comb
    begin
        pop         = (!active_reg || done) && !qstat.empty;
        active_next = active_reg;
        seg_next    = seg_reg;
        idx_next    = idx_reg;
        sub_next    = sub_reg + 2'd1;

        if (!active_reg || done)
        begin
            // Load the next byte straight away so phases run back to back
            active_next = !qstat.empty;
            seg_next    = head_desc.has_start ? SEG_START : SEG_BITS;
            idx_next    = '0;
            sub_next    = '0;
        end
        else
        begin
            case (seg_reg)
                SEG_START:
                begin
                    if (sub_reg == SUB_LAST_START)
                    begin
                        seg_next = SEG_BITS;
                        sub_next = '0;
                    end
                end
                SEG_BITS:
                begin
                    if (sub_reg == SUB_LAST_BIT)
                    begin
                        sub_next = '0;
                        if (idx_reg == IDX_LAST_BIT)
                        begin
                            seg_next = SEG_ACK;
                        end
                        else
                        begin
                            idx_next = idx_reg + 3'd1;
                        end
                    end
                end
                SEG_ACK:
                begin
                    if (sub_reg == SUB_LAST_ACK)
                    begin
                        seg_next = SEG_STOP;
                        sub_next = '0;
                    end
                end
                default:
                begin
                    sub_next = sub_reg + 2'd1;
                end
            endcase
        end
    end

    // Pin levels of the current phase
    always_comb
    begin
        strobe        = active_reg;
        last_phase    = active_reg && done;
        clock_level   = 1'b0;
        data_level    = 1'b0;
        data_released = 1'b0;
        case (seg_reg)
            SEG_START:
            begin
                clock_level = (sub_reg != SUB_LAST_START);
                data_level  = (sub_reg < 2'd2);
            end
            SEG_BITS:
            begin
                clock_level = (sub_reg == SUB_LAST_BIT);
                if (sub_reg == 2'd0)
                begin
                    // Clock-low phase still shows what the line held before
                    if (idx_reg == 3'd0)
                    begin
                        data_released = !desc_reg.has_start;
                    end
                    else
                    begin
                        data_level = desc_reg.value[prev_idx];
                    end
                end
                else
                begin
                    data_level = desc_reg.value[idx_reg];
                end
            end
            SEG_ACK:
            begin
                clock_level   = (sub_reg == 2'd1);
                data_released = 1'b1;
            end
            SEG_STOP:
            begin
                clock_level   = (sub_reg >= 2'd2);
                data_level    = (sub_reg == SUB_LAST_STOP);
                data_released = (sub_reg == 2'd0);
            end
            default:
            begin
                clock_level = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            seg_reg    <= SEG_START;
            idx_reg    <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            seg_reg    <= seg_next;
            idx_reg    <= idx_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= head_desc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/led_driver_two_wire_byte_serializer_top.sv =====
// Top level of the two-wire LED driver byte serializer.
// Instantiates ledser_front, ledser_queue and ledser_back; uses ledser_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  request  | start in, busy out     | req_type, byte_value, last_data
//  phase    | strobe out, no stall   | clock_level, data_level, data_released,
//           |                        | last_phase
//
// A byte yields 35, 31 or 27 phases, one per cycle, from the back-end sequencer.
// Accepted bytes wait in a QUEUE_DEPTH-entry queue; busy is high while it is full.
// The sequencer takes the next byte on the final phase of the current one, so
// phases of consecutive bytes follow with no gap when the next byte is queued.
// Reset empties the queue and idles the sequencer. The receiver cannot stall.
`default_nettype none

module led_driver_two_wire_byte_serializer_top
    import ledser_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       req_type,
    input  wire logic [7:0] byte_value,
    input  wire logic       last_data,
    output logic            strobe,
    output logic            clock_level,
    output logic            data_level,
    output logic            data_released,
    output logic            last_phase
);

    ledser_qstat_t qstat;
    ledser_desc_t  push_desc;
    ledser_desc_t  head_desc;
    logic          push;
    logic          pop;

    ledser_front u_front (
        .start      (start),
        .req_type   (req_type),
        .byte_value (byte_value),
        .last_data  (last_data),
        .qstat      (qstat),
        .busy       (busy),
        .push       (push),
        .push_desc  (push_desc)
    );

    ledser_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .qstat     (qstat)
    );

    ledser_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_desc     (head_desc),
        .qstat         (qstat),
        .pop           (pop),
        .strobe        (strobe),
        .clock_level   (clock_level),
        .data_level    (data_level),
        .data_released (data_released),
        .last_phase    (last_phase)
    );

endmodule

`default_nettype wire

// ===== verif/led_driver_two_wire_byte_serializer_top_tb.sv =====
// Testbench for the two-wire LED driver byte serializer top level.
// Depends on ledser_pkg and led_driver_two_wire_byte_serializer_top; predicts every pin phase
// of each accepted byte and checks the strobed phases in order.
`timescale 1ns / 100ps

module led_driver_two_wire_byte_serializer_top_tb;
    import ledser_pkg::*;

    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_DATA = 1'b1;
    localparam int   QUIET_LIMIT = 1000;
    localparam int   DRAIN_CYCLES = 40;

    typedef struct packed {
        logic scl;
        logic sda;
        logic rel;
        logic fin;
    } pin_phase_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       req_type = 1'b0;
    logic [7:0] byte_value = 8'h00;
    logic       last_data = 1'b0;
    logic       busy;
    logic       strobe;
    logic       clock_level;
    logic       data_level;
    logic       data_released;
    logic       last_phase;

    pin_phase_t pending_phases[$];
    logic       line_clk;
    logic       line_dat;
    logic       line_rel;
    int         errors = 0;
    int         bytes_sent = 0;
    int         cmds_sent = 0;
    int         phases_seen = 0;
    int         quiet_cycles = 0;
    bit         idle_on = 1'b1;

    led_driver_two_wire_byte_serializer_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .byte_value    (byte_value),
        .last_data     (last_data),
        .strobe        (strobe),
        .clock_level   (clock_level),
        .data_level    (data_level),
        .data_released (data_released),
        .last_phase    (last_phase)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Line mirror: every pin move yields one phase
    function automatic void emit_line();
        pending_phases.push_back('{line_clk, line_rel ? 1'b0 : line_dat, line_rel, 1'b0});
    endfunction

    function automatic void move_clock(logic level);
        line_clk = level;
        emit_line();
    endfunction

    function automatic void move_data(logic level);
        line_dat = level;
        line_rel = 1'b0;
        emit_line();
    endfunction

    function automatic void plan_byte_phases(logic kind, logic [7:0] value, logic last);
        logic with_stop;
        if (kind == REQ_CMD)
        begin
            // start condition from an idle bus
            line_clk = 1'b1;
            line_dat = 1'b1;
            line_rel = 1'b0;
            move_clock(1'b1);
            move_data(1'b1);
            move_data(1'b0);
            move_clock(1'b0);
            with_stop = (value[7:6] != NO_STOP_BITS);
        end
        else
        begin
            // previous ack slot left the clock low and data released
            line_clk = 1'b0;
            line_dat = 1'b0;
            line_rel = 1'b1;
            with_stop = last;
        end
        for (int i = 0; i < 8; i++)
        begin
            move_clock(1'b0);
            move_data(value[i]);
            move_clock(1'b1);
        end
        line_rel = 1'b1;
        line_dat = 1'b0;
        move_clock(1'b0);
        move_clock(1'b1);
        move_clock(1'b0);
        if (with_stop)
        begin
            move_clock(1'b0);
            move_data(1'b0);
            move_clock(1'b1);
            move_data(1'b1);
        end
        pending_phases[pending_phases.size() - 1].fin = 1'b1;
    endfunction

    function automatic void report_field(string name, logic want, logic got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
        end
    endfunction

    // Predict on each accepted byte, then check each strobed phase
    always @(posedge clk)
    begin
        pin_phase_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                plan_byte_phases(req_type, byte_value, last_data);
            end
            if (strobe)
            begin
                phases_seen++;
                if (pending_phases.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected phase, expected none, actual clk=%b dat=%b rel=%b last=%b",
                             $time, clock_level, data_level, data_released, last_phase);
                end
                else
                begin
                    want = pending_phases.pop_front();
                    report_field("clock_level", want.scl, clock_level);
                    report_field("data_level", want.sda, data_level);
                    report_field("data_released", want.rel, data_released);
                    report_field("last_phase", want.fin, last_phase);
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d phases outstanding",
                         $time, QUIET_LIMIT, pending_phases.size());
                $display("led_driver_two_wire_byte_serializer_top_tb: FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_byte(logic kind, logic [7:0] value, logic last);
        start <= 1'b1;
        req_type <= kind;
        byte_value <= value;
        last_data <= last;
        do
            @(posedge clk);
        while (busy);
        bytes_sent++;
        if (kind == REQ_CMD)
        begin
            cmds_sent++;
        end
        // hold off the next transfer now and then
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic send_burst(logic [7:0] lead_cmd, int count);
        send_byte(REQ_CMD, lead_cmd, 1'($urandom));
        for (int i = 0; i < count; i++)
        begin
            send_byte(REQ_DATA, 8'($urandom), logic'(i == count - 1));
        end
    endtask

    task automatic test_directed_commands();
        logic [7:0] picks[10] = '{8'h00, 8'hFF, 8'hC0, 8'hBF, 8'h80, 8'h40,
                                  8'h3F, 8'h7F, 8'h55, 8'hAA};
        foreach (picks[i])
        begin
            // last_data toggled to show it has no effect on commands
            send_byte(REQ_CMD, picks[i], logic'(i % 2));
        end
    endtask

    task automatic test_directed_data();
        send_byte(REQ_CMD, 8'hC0, 1'b0);
        send_byte(REQ_DATA, 8'h00, 1'b0);
        send_byte(REQ_DATA, 8'hFF, 1'b0);
        send_byte(REQ_DATA, 8'h01, 1'b0);
        send_byte(REQ_DATA, 8'h80, 1'b1);
        send_byte(REQ_DATA, 8'hFF, 1'b1);
        send_byte(REQ_DATA, 8'h00, 1'b1);
        send_byte(REQ_DATA, 8'hA5, 1'b0);
        send_byte(REQ_CMD, 8'h88, 1'b0);
    endtask

    task automatic test_random_traffic(int target);
        int start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    // address command with no stop, then a data burst
                    send_burst({NO_STOP_BITS, 6'($urandom)}, $urandom_range(1, 6));
                6:
                    send_burst(8'($urandom), $urandom_range(0, 3));
                7:
                    // burst that never flags its last byte
                    for (int i = $urandom_range(1, 4); i > 0; i--)
                    begin
                        send_byte(REQ_DATA, 8'($urandom), 1'b0);
                    end
                default:
                    send_byte(1'($urandom), 8'($urandom), 1'($urandom));
            endcase
        end
    endtask

    task automatic test_back_to_back(int target);
        idle_on = 1'b0;
        for (int i = 0; i < target; i++)
        begin
            send_byte(1'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_commands();
        test_directed_data();
        test_random_traffic(230);
        test_back_to_back(30);
        start <= 1'b0;
        while (pending_phases.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes (%0d commands, %0d data) and checked %0d pin phases.",
                 bytes_sent, cmds_sent, bytes_sent - cmds_sent, phases_seen);
        $display("Mismatches found: %0d", errors);
        if (errors == 0)
        begin
            $display("led_driver_two_wire_byte_serializer_top_tb: PASS");
        end
        else
        begin
            $display("led_driver_two_wire_byte_serializer_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ledser_pkg.sv
rtl/ledser_front.sv
rtl/ledser_queue.sv
rtl/ledser_back.sv
rtl/led_driver_two_wire_byte_serializer_top.sv
verif/led_driver_two_wire_byte_serializer_top_tb.sv
